[rtl/core/sble_pkg.sv]
`timescale 1ns / 1ps
package sble_pkg;

    localparam int BAR_COUNT = 8;
    localparam int BIN_COUNT = 32;

    localparam logic [1:0] GRP_LOW  = 2'd0;
    localparam logic [1:0] GRP_MID  = 2'd1;
    localparam logic [1:0] GRP_HIGH = 2'd2;

    localparam logic [1:0] CFG_SMOOTHING_RATE = 2'd0;
    localparam logic [1:0] CFG_PEAK_FLOOR     = 2'd1;

    localparam logic [7:0]  SMOOTH_RESET     = 8'd77;
    localparam logic [15:0] FLOOR_RESET      = 16'd655;
    localparam logic [23:0] PEAK_LOW_RESET   = 24'd6554;
    localparam logic [23:0] PEAK_MID_RESET   = 24'd6554;
    localparam logic [23:0] PEAK_HIGH_RESET  = 24'd5243;

    localparam logic [16:0] COEF_RISE_OLD  = 17'd45875;
    localparam logic [14:0] COEF_RISE_NEW  = 15'd19661;
    localparam logic [16:0] COEF_DECAY_LOW = 17'd64881;
    localparam logic [16:0] COEF_DECAY_MID = 17'd65208;
    localparam logic [16:0] COEF_DECAY_HI  = 17'd65536;
    localparam logic [14:0] DAMP_GAIN      = 15'd19661;
    localparam logic [17:0] DAMP_LOWS_MIN  = 18'd52428;
    localparam logic [18:0] DAMP_MIDS_MAX  = 19'd19660;
    localparam logic [17:0] DAMP_HIGHS_MAX = 18'd13107;
    localparam logic [16:0] LEVEL_MIN      = 17'd66;
    localparam logic [16:0] LEVEL_ONE      = 17'd65536;
    localparam logic [17:0] NORM_MAX       = 18'd131072;

    localparam logic [2:0] BAND_OF_BIN [BIN_COUNT] = '{
        3'd0, 3'd0, 3'd0, 3'd0, 3'd1, 3'd1, 3'd1, 3'd2,
        3'd2, 3'd2, 3'd2, 3'd3, 3'd3, 3'd3, 3'd3, 3'd4,
        3'd4, 3'd4, 3'd4, 3'd5, 3'd5, 3'd5, 3'd5, 3'd6,
        3'd6, 3'd6, 3'd6, 3'd7, 3'd7, 3'd7, 3'd7, 3'd7
    };

    localparam logic [14:0] WEIGHT_OF_BIN [BIN_COUNT] = '{
        15'd0,     15'd9830,  15'd13107, 15'd9830,
        15'd13763, 15'd18350, 15'd13763, 15'd16384,
        15'd19661, 15'd16384, 15'd13107, 15'd13107,
        15'd19661, 15'd19661, 15'd13107, 15'd13107,
        15'd19661, 15'd19661, 15'd13107, 15'd13107,
        15'd19661, 15'd19661, 15'd26214, 15'd6554,
        15'd26214, 15'd19661, 15'd13107, 15'd13173,
        15'd13173, 15'd19759, 15'd13173, 15'd0
    };

    typedef struct packed {
        logic       acc_mul;
        logic       acc_add;
        logic       gmax_ld;
        logic       pk_a;
        logic       pk_b;
        logic       pk_c;
        logic       div_init;
        logic       div_step;
        logic       div_done;
        logic       damp_ld;
        logic       sm_a;
        logic       sm_b;
        logic       sm_c;
        logic [1:0] grp;
        logic [2:0] bar;
    } t_cmd;

    typedef struct packed {
        logic last;
        logic out_taken;
    } t_status;

    function automatic logic [1:0] group_of_bar(input logic [2:0] bar);
        logic [1:0] g;
        if (bar < 3'd2) begin
            g = GRP_LOW;
        end else if (bar < 3'd6) begin
            g = GRP_MID;
        end else begin
            g = GRP_HIGH;
        end
        return g;
    endfunction

    // elaboration-time helpers for the curve tables
    function automatic longint unsigned isqrt_u64(input longint unsigned n);
        longint unsigned res;
        longint unsigned bit_v;
        longint unsigned rem;
        res   = 64'd0;
        bit_v = 64'd1 << 62;
        rem   = n;
        for (int i = 0; i < 32; i++) begin
            if (bit_v > rem) bit_v = bit_v >> 2;
        end
        for (int i = 0; i < 32; i++) begin
            if (bit_v != 64'd0) begin
                if (rem >= res + bit_v) begin
                    rem = rem - (res + bit_v);
                    res = (res >> 1) + bit_v;
                end else begin
                    res = res >> 1;
                end
                bit_v = bit_v >> 2;
            end
        end
        return res;
    endfunction

    // long division, table build only
    function automatic longint unsigned udiv_u64(input longint unsigned num,
                                                 input longint unsigned den);
        longint unsigned quo;
        longint unsigned rem;
        quo = 64'd0;
        rem = 64'd0;
        for (int i = 63; i >= 0; i--) begin
            rem = (rem << 1) | ((num >> i) & 64'd1);
            if (rem >= den) begin
                rem = rem - den;
                quo = quo | (64'd1 << i);
            end
        end
        return quo;
    endfunction

    // signed quotient truncated toward zero
    function automatic longint sdiv_trunc(input longint num, input longint unsigned den);
        longint unsigned mag;
        longint unsigned qm;
        mag = (num < 0) ? longint'(-num) : longint'(num);
        qm  = udiv_u64(mag, den);
        return (num < 0) ? -longint'(qm) : longint'(qm);
    endfunction

    function automatic longint log2_q16(input longint unsigned v);
        int              k;
        longint unsigned y;
        longint          r;
        k = 0;
        for (int t = 0; t < 12; t++) begin
            if (k == t && (v >> (t + 1)) != 64'd0) k = t + 1;
        end
        y = v << (30 - k);
        r = longint'(k) << 16;
        for (int b = 15; b >= 0; b--) begin
            y = (y * y) >> 30;
            if (y >= (64'd1 << 31)) begin
                y = y >> 1;
                r = r | (64'sd1 << b);
            end
        end
        return r;
    endfunction

    function automatic logic [16:0] curve_entry(input int g, input int i, input int depth);
        longint unsigned root [16];
        longint          lx;
        longint          e;
        longint unsigned ue;
        longint unsigned q;
        longint unsigned f;
        longint unsigned v;
        longint unsigned x;
        longint unsigned val;
        root[0] = isqrt_u64(64'd2 << 60);
        for (int j = 1; j < 16; j++) root[j] = isqrt_u64(root[j-1] << 30);
        if (i == 0) return 17'd0;
        lx = log2_q16(longint'(2 * i)) - log2_q16(longint'(depth));
        case (g)
            0:       e = sdiv_trunc(lx * 2, 64'd5);
            1:       e = sdiv_trunc(lx * 3, 64'd5);
            default: e = sdiv_trunc(lx * 7, 64'd10);
        endcase
        e  = e + (64'sd16 <<< 16);
        ue = (e < 0) ? 64'd0 : longint'(e);
        q  = (ue >> 16) & 64'd31;
        f  = ue & 64'hFFFF;
        v  = 64'd1 << 30;
        for (int j = 0; j < 16; j++) begin
            if (f[15-j]) v = (v * root[j] + (64'd1 << 29)) >> 30;
        end
        x = v << q;
        case (g)
            0:       val = udiv_u64(x * 4 + (64'd5 << 29), 64'd5 << 30);
            1:       val = udiv_u64(x * 6 + (64'd5 << 29), 64'd5 << 30);
            default: val = udiv_u64(x * 3 + (64'd2 << 29), 64'd2 << 30);
        endcase
        return (val > 64'd65536) ? 17'd65536 : val[16:0];
    endfunction

endpackage

[rtl/core/sble_ctrl.sv]
`timescale 1ns / 1ps
module sble_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_bin_valid,
    output logic             o_bin_ready,
    input  sble_pkg::t_status i_status,
    output sble_pkg::t_cmd   o_cmd
);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_ACC      = 4'd1;
    localparam logic [3:0] S_GMAX     = 4'd2;
    localparam logic [3:0] S_PK_A     = 4'd3;
    localparam logic [3:0] S_PK_B     = 4'd4;
    localparam logic [3:0] S_PK_C     = 4'd5;
    localparam logic [3:0] S_DIV_INIT = 4'd6;
    localparam logic [3:0] S_DIV_STEP = 4'd7;
    localparam logic [3:0] S_DIV_DONE = 4'd8;
    localparam logic [3:0] S_DAMP     = 4'd9;
    localparam logic [3:0] S_SM_A     = 4'd10;
    localparam logic [3:0] S_SM_B     = 4'd11;
    localparam logic [3:0] S_SM_C     = 4'd12;
    localparam logic [3:0] S_EMIT     = 4'd13;

    localparam logic [4:0] DIV_LAST_BIT = 5'd17;

    logic [3:0] r_state, n_state;
    logic [2:0] r_bar, n_bar;
    logic [1:0] r_grp, n_grp;
    logic [4:0] r_bit, n_bit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_bar   <= 3'd0;
            r_grp   <= 2'd0;
            r_bit   <= 5'd0;
        end else begin
            r_state <= n_state;
            r_bar   <= n_bar;
            r_grp   <= n_grp;
            r_bit   <= n_bit;
        end
    end

    always_comb begin
        n_state = r_state;
        n_bar   = r_bar;
        n_grp   = r_grp;
        n_bit   = r_bit;
        o_cmd   = '0;
        o_cmd.bar = r_bar;
        o_cmd.grp = r_grp;
        o_bin_ready = (r_state == S_IDLE);
        unique case (r_state)
            S_IDLE: begin
                if (i_bin_valid) begin
                    o_cmd.acc_mul = 1'b1;
                    n_state = S_ACC;
                end
            end
            S_ACC: begin
                o_cmd.acc_add = 1'b1;
                n_state = i_status.last ? S_GMAX : S_IDLE;
            end
            S_GMAX: begin
                o_cmd.gmax_ld = 1'b1;
                n_grp   = sble_pkg::GRP_LOW;
                n_state = S_PK_A;
            end
            S_PK_A: begin
                o_cmd.pk_a = 1'b1;
                n_state = S_PK_B;
            end
            S_PK_B: begin
                o_cmd.pk_b = 1'b1;
                n_state = S_PK_C;
            end
            S_PK_C: begin
                o_cmd.pk_c = 1'b1;
                if (r_grp == sble_pkg::GRP_HIGH) begin
                    n_bar   = 3'd0;
                    n_state = S_DIV_INIT;
                end else begin
                    n_grp   = r_grp + 2'd1;
                    n_state = S_PK_A;
                end
            end
            S_DIV_INIT: begin
                o_cmd.div_init = 1'b1;
                n_bit   = DIV_LAST_BIT;
                n_state = S_DIV_STEP;
            end
            S_DIV_STEP: begin
                o_cmd.div_step = 1'b1;
                n_bit = r_bit - 5'd1;
                if (r_bit == 5'd0) n_state = S_DIV_DONE;
            end
            S_DIV_DONE: begin
                o_cmd.div_done = 1'b1;
                if (r_bar == 3'd7) begin
                    n_state = S_DAMP;
                end else begin
                    n_bar   = r_bar + 3'd1;
                    n_state = S_DIV_INIT;
                end
            end
            S_DAMP: begin
                o_cmd.damp_ld = 1'b1;
                n_bar   = 3'd0;
                n_state = S_SM_A;
            end
            S_SM_A: begin
                o_cmd.sm_a = 1'b1;
                n_state = S_SM_B;
            end
            S_SM_B: begin
                o_cmd.sm_b = 1'b1;
                n_state = S_SM_C;
            end
            S_SM_C: begin
                o_cmd.sm_c = 1'b1;
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (i_status.out_taken) begin
                    if (r_bar == 3'd7) begin
                        n_state = S_IDLE;
                    end else begin
                        n_bar   = r_bar + 3'd1;
                        n_state = S_SM_A;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

[rtl/core/sble_datapath.sv]
`timescale 1ns / 1ps
module sble_datapath #(
    parameter int LEDS_PER_COLUMN   = 8,
    parameter int CURVE_TABLE_DEPTH = 256
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  sble_pkg::t_cmd    i_cmd,
    output sble_pkg::t_status o_status,
    input  logic [23:0]       i_magnitude,
    input  logic [4:0]        i_bin_index,
    input  logic              i_last_bin,
    input  logic              i_cfg_valid,
    input  logic [1:0]        i_cfg_index,
    input  logic [15:0]       i_cfg_data,
    output logic              o_bar_valid,
    input  logic              i_bar_ready,
    output logic [2:0]        o_bar_index,
    output logic [3:0]        o_led_count,
    output logic [16:0]       o_bar_level,
    output logic              o_last_bar
);

    localparam int IDX_W   = $clog2(CURVE_TABLE_DEPTH);
    localparam int NPROD_W = 18 + $clog2(CURVE_TABLE_DEPTH + 1);
    localparam int LED_W   = 17 + $clog2(LEDS_PER_COLUMN + 1);
    localparam int LED_CAP = (LEDS_PER_COLUMN > 15) ? 15 : LEDS_PER_COLUMN;

    typedef logic [CURVE_TABLE_DEPTH-1:0][16:0] t_curve_row;

    function automatic t_curve_row build_row(input int g);
        t_curve_row row;
        for (int i = 0; i < CURVE_TABLE_DEPTH; i++) begin
            row[i] = sble_pkg::curve_entry(g, i, CURVE_TABLE_DEPTH);
        end
        return row;
    endfunction

    localparam t_curve_row CURVE_LOW  = build_row(0);
    localparam t_curve_row CURVE_MID  = build_row(1);
    localparam t_curve_row CURVE_HIGH = build_row(2);

    logic [7:0]  r_rate;
    logic [15:0] r_floor;
    logic [31:0] r_band_sum [sble_pkg::BAR_COUNT];
    logic [23:0] r_peak [3];
    logic [31:0] r_gmax [3];
    logic [16:0] r_target [sble_pkg::BAR_COUNT];
    logic [16:0] r_level [sble_pkg::BAR_COUNT];

    logic [38:0] r_term_prod;
    logic [2:0]  r_band;
    logic        r_last;
    logic        r_rise;
    logic [40:0] r_prod_a;
    logic [46:0] r_prod_b;
    logic [23:0] r_dpeak;
    logic        r_zero;
    logic        r_sat;
    logic [23:0] r_rem;
    logic [17:0] r_dvd;
    logic [17:0] r_quo;
    logic        r_damp;
    logic [16:0] r_eff;
    logic        r_up;
    logic [24:0] r_sprod;
    logic        r_out_valid;
    logic [2:0]  r_out_bar;
    logic [3:0]  r_out_led;
    logic [16:0] r_out_level;

    // accumulate
    logic [32:0] acc_sum;
    logic [23:0] acc_term;
    assign acc_term = 24'((r_term_prod + 39'd32768) >> 16);
    assign acc_sum  = {1'b0, r_band_sum[r_band]} + {9'd0, acc_term};

    // peak update
    logic [23:0] pk_peak;
    logic [31:0] pk_gmax;
    logic        pk_rise;
    logic [16:0] pk_coef;
    logic [47:0] pk_sum;
    logic [31:0] pk_raw;
    logic [23:0] pk_new;
    assign pk_peak = r_peak[i_cmd.grp];
    assign pk_gmax = r_gmax[i_cmd.grp];
    assign pk_rise = pk_gmax > {8'd0, pk_peak};
    always_comb begin
        unique case (i_cmd.grp)
            sble_pkg::GRP_LOW: pk_coef = sble_pkg::COEF_DECAY_LOW;
            sble_pkg::GRP_MID: pk_coef = sble_pkg::COEF_DECAY_MID;
            default:           pk_coef = sble_pkg::COEF_DECAY_HI;
        endcase
        if (pk_rise) pk_coef = sble_pkg::COEF_RISE_OLD;
    end
    assign pk_sum = {7'd0, r_prod_a} + (r_rise ? {1'b0, r_prod_b} : 48'd0) + 48'd32768;
    assign pk_raw = pk_sum[47:16];
    always_comb begin
        pk_new = (pk_raw > 32'hFF_FFFF) ? 24'hFF_FFFF : pk_raw[23:0];
        if (pk_new < {8'd0, r_floor}) pk_new = {8'd0, r_floor};
    end

    // restoring divide, one quotient bit a cycle
    logic [2:0]  bar;
    logic [1:0]  bar_grp;
    logic [31:0] dv_band;
    logic [23:0] dv_peak;
    logic [24:0] dv_trial;
    logic        dv_ge;
    logic [24:0] dv_diff;
    assign bar      = i_cmd.bar;
    assign bar_grp  = sble_pkg::group_of_bar(bar);
    assign dv_band  = r_band_sum[bar];
    assign dv_peak  = r_peak[bar_grp];
    assign dv_trial = {r_rem, r_dvd[17]};
    assign dv_ge    = dv_trial >= {1'b0, r_dpeak};
    assign dv_diff  = dv_trial - {1'b0, r_dpeak};

    // curve lookup
    logic [17:0]        norm;
    logic [NPROD_W-1:0] norm_prod;
    logic [NPROD_W-1:0] idx_full;
    logic [IDX_W-1:0]   idx;
    logic [16:0]        curve_val;
    assign norm = (r_sat || r_quo > sble_pkg::NORM_MAX) ? sble_pkg::NORM_MAX : r_quo;
    assign norm_prod = NPROD_W'(norm) * NPROD_W'(CURVE_TABLE_DEPTH);
    assign idx_full  = norm_prod >> 17;
    assign idx = (idx_full > NPROD_W'(CURVE_TABLE_DEPTH - 1)) ?
                 IDX_W'(CURVE_TABLE_DEPTH - 1) : idx_full[IDX_W-1:0];
    always_comb begin
        unique case (bar_grp)
            sble_pkg::GRP_LOW: curve_val = CURVE_LOW[idx];
            sble_pkg::GRP_MID: curve_val = CURVE_MID[idx];
            default:           curve_val = CURVE_HIGH[idx];
        endcase
    end

    // low-only damping test
    logic [17:0] lows;
    logic [18:0] mids;
    logic [17:0] highs;
    assign lows  = {1'b0, r_target[0]} + {1'b0, r_target[1]};
    assign mids  = {2'b0, r_target[2]} + {2'b0, r_target[3]} +
                   {2'b0, r_target[4]} + {2'b0, r_target[5]};
    assign highs = {1'b0, r_target[6]} + {1'b0, r_target[7]};

    // smoothing
    logic [31:0] damp_prod;
    logic [16:0] sm_lv;
    logic [16:0] sm_diff;
    logic [16:0] sm_step;
    logic [17:0] sm_new;
    logic [LED_W-1:0] led_prod;
    logic [LED_W-1:0] led_raw;
    assign damp_prod = r_target[bar] * sble_pkg::DAMP_GAIN + 32'd32768;
    assign sm_lv     = r_level[bar];
    assign sm_diff   = (r_eff >= sm_lv) ? (r_eff - sm_lv) : (sm_lv - r_eff);
    assign sm_step   = 17'((26'(r_sprod) + 26'd128) >> 8);
    always_comb begin
        if (r_up) begin
            sm_new = {1'b0, sm_lv} + {1'b0, sm_step};
        end else begin
            sm_new = (sm_step > sm_lv) ? 18'd0 : {1'b0, sm_lv - sm_step};
        end
        if (sm_new < {1'b0, sble_pkg::LEVEL_MIN}) sm_new = 18'd0;
        if (sm_new > {1'b0, sble_pkg::LEVEL_ONE}) sm_new = {1'b0, sble_pkg::LEVEL_ONE};
    end
    assign led_prod = LED_W'(sm_new[16:0]) * LED_W'(LEDS_PER_COLUMN) + LED_W'(32768);
    assign led_raw  = led_prod >> 16;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate      <= sble_pkg::SMOOTH_RESET;
            r_floor     <= sble_pkg::FLOOR_RESET;
            r_peak[0]   <= sble_pkg::PEAK_LOW_RESET;
            r_peak[1]   <= sble_pkg::PEAK_MID_RESET;
            r_peak[2]   <= sble_pkg::PEAK_HIGH_RESET;
            r_out_valid <= 1'b0;
            r_last      <= 1'b0;
            for (int b = 0; b < sble_pkg::BAR_COUNT; b++) begin
                r_band_sum[b] <= 32'd0;
                r_level[b]    <= 17'd0;
            end
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    sble_pkg::CFG_SMOOTHING_RATE: r_rate  <= i_cfg_data[7:0];
                    sble_pkg::CFG_PEAK_FLOOR:     r_floor <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.acc_mul) r_last <= i_last_bin;
            if (i_cmd.acc_add) begin
                r_band_sum[r_band] <= acc_sum[32] ? 32'hFFFF_FFFF : acc_sum[31:0];
            end
            if (i_cmd.pk_c) r_peak[i_cmd.grp] <= pk_new;
            if (i_cmd.sm_c) begin
                r_level[bar]    <= sm_new[16:0];
                r_band_sum[bar] <= 32'd0;
                r_out_valid     <= 1'b1;
            end else if (r_out_valid && i_bar_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.acc_mul) begin
            r_term_prod <= i_magnitude * sble_pkg::WEIGHT_OF_BIN[i_bin_index];
            r_band      <= sble_pkg::BAND_OF_BIN[i_bin_index];
        end
        if (i_cmd.gmax_ld) begin
            r_gmax[0] <= (r_band_sum[0] > r_band_sum[1]) ? r_band_sum[0] : r_band_sum[1];
            r_gmax[1] <= (((r_band_sum[2] > r_band_sum[3]) ? r_band_sum[2] : r_band_sum[3]) >
                          ((r_band_sum[4] > r_band_sum[5]) ? r_band_sum[4] : r_band_sum[5])) ?
                         ((r_band_sum[2] > r_band_sum[3]) ? r_band_sum[2] : r_band_sum[3]) :
                         ((r_band_sum[4] > r_band_sum[5]) ? r_band_sum[4] : r_band_sum[5]);
            r_gmax[2] <= (r_band_sum[6] > r_band_sum[7]) ? r_band_sum[6] : r_band_sum[7];
        end
        if (i_cmd.pk_a) begin
            r_rise   <= pk_rise;
            r_prod_a <= pk_peak * pk_coef;
        end
        if (i_cmd.pk_b) r_prod_b <= pk_gmax * sble_pkg::COEF_RISE_NEW;
        if (i_cmd.div_init) begin
            r_dpeak <= dv_peak;
            r_zero  <= (dv_peak == 24'd0);
            r_sat   <= dv_band >= {6'd0, dv_peak, 2'b00};
            r_rem   <= dv_band[25:2];
            r_dvd   <= {dv_band[1:0], 16'd0};
            r_quo   <= 18'd0;
        end
        if (i_cmd.div_step) begin
            r_rem <= dv_ge ? dv_diff[23:0] : dv_trial[23:0];
            r_dvd <= {r_dvd[16:0], 1'b0};
            r_quo <= {r_quo[16:0], dv_ge};
        end
        if (i_cmd.div_done) r_target[bar] <= r_zero ? 17'd0 : curve_val;
        if (i_cmd.damp_ld) begin
            r_damp <= (lows > sble_pkg::DAMP_LOWS_MIN) && (mids <= sble_pkg::DAMP_MIDS_MAX) &&
                      (highs <= sble_pkg::DAMP_HIGHS_MAX);
        end
        if (i_cmd.sm_a) begin
            r_eff <= (r_damp && bar < 3'd2) ? {1'b0, damp_prod[31:16]} : r_target[bar];
        end
        if (i_cmd.sm_b) begin
            r_up    <= r_eff >= sm_lv;
            r_sprod <= sm_diff * r_rate;
        end
        if (i_cmd.sm_c) begin
            r_out_bar   <= bar;
            r_out_level <= sm_new[16:0];
            r_out_led   <= (led_raw > LED_W'(LED_CAP)) ? 4'(LED_CAP) : led_raw[3:0];
        end
    end

    assign o_status.last      = r_last;
    assign o_status.out_taken = r_out_valid && i_bar_ready;

    assign o_bar_valid = r_out_valid;
    assign o_bar_index = r_out_bar;
    assign o_led_count = r_out_led;
    assign o_bar_level = r_out_level;
    assign o_last_bar  = (r_out_bar == 3'd7);

endmodule

[rtl/core/spectrum_bar_level_engine.sv]
`timescale 1ns / 1ps
// Each bin item takes a registered weight multiply, then a saturating band add.
// A last-bin item then runs the frame end: a group-max step, peak update for the three groups,
// per-bar 1-bit-per-cycle division and curve lookup, a damping step, then smoothing and
// output per bar, held by any output stall; bins are held off until the eighth bar is taken.
// Synchronous active-low reset clears band sums, bar levels and output valid, and
// loads the default peaks and register values.
module spectrum_bar_level_engine #(
    parameter int LEDS_PER_COLUMN   = 8,
    parameter int CURVE_TABLE_DEPTH = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_bin_valid,
    output logic        o_bin_ready,
    input  logic [23:0] i_magnitude,
    input  logic [4:0]  i_bin_index,
    input  logic        i_last_bin,
    output logic        o_bar_valid,
    input  logic        i_bar_ready,
    output logic [2:0]  o_bar_index,
    output logic [3:0]  o_led_count,
    output logic [16:0] o_bar_level,
    output logic        o_last_bar,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    sble_pkg::t_cmd    cmd;
    sble_pkg::t_status status;

    assign o_cfg_ready = 1'b1;

    sble_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_bin_valid (i_bin_valid),
        .o_bin_ready (o_bin_ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    sble_datapath #(
        .LEDS_PER_COLUMN   (LEDS_PER_COLUMN),
        .CURVE_TABLE_DEPTH (CURVE_TABLE_DEPTH)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_magnitude (i_magnitude),
        .i_bin_index (i_bin_index),
        .i_last_bin  (i_last_bin),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_bar_valid (o_bar_valid),
        .i_bar_ready (i_bar_ready),
        .o_bar_index (o_bar_index),
        .o_led_count (o_led_count),
        .o_bar_level (o_bar_level),
        .o_last_bar  (o_last_bar)
    );

endmodule

[tb/spectrum_bar_level_engine_tb.sv]
`timescale 1ns / 1ps
module spectrum_bar_level_engine_tb;

    localparam int LEDS      = 8;
    localparam int DEPTH     = 256;
    localparam int STALL_MAX = 3000;
    localparam int HOLD_LEN  = 400;

    typedef struct packed {
        logic [2:0]  bar;
        logic [3:0]  leds;
        logic [16:0] level;
        logic        last;
    } t_bar_item;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_bin_valid;
    logic        o_bin_ready;
    logic [23:0] i_magnitude;
    logic [4:0]  i_bin_index;
    logic        i_last_bin;
    logic        o_bar_valid;
    logic        i_bar_ready;
    logic [2:0]  o_bar_index;
    logic [3:0]  o_led_count;
    logic [16:0] o_bar_level;
    logic        o_last_bar;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [15:0] i_cfg_data;

    spectrum_bar_level_engine #(
        .LEDS_PER_COLUMN(LEDS),
        .CURVE_TABLE_DEPTH(DEPTH)
    ) uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_bin_valid(i_bin_valid), .o_bin_ready(o_bin_ready),
        .i_magnitude(i_magnitude), .i_bin_index(i_bin_index), .i_last_bin(i_last_bin),
        .o_bar_valid(o_bar_valid), .i_bar_ready(i_bar_ready),
        .o_bar_index(o_bar_index), .o_led_count(o_led_count),
        .o_bar_level(o_bar_level), .o_last_bar(o_last_bar),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    // predictor state
    logic [7:0]  rate_q;
    logic [15:0] floor_q;
    logic [31:0] band_acc [sble_pkg::BAR_COUNT];
    logic [23:0] grp_peak [3];
    logic [16:0] level_q  [sble_pkg::BAR_COUNT];
    logic [16:0] curve    [3][DEPTH];
    t_bar_item   bars_pending [$];

    int  err_count;
    int  items_sent;
    bit  tx_idle_en;
    bit  rx_idle_en;
    bit  hold_req;
    bit  hold_ack;
    int  rx_wait;
    int  stall_cycles;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    task automatic report(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
        err_count++;
    endtask

    // ---------------- curve tables ----------------
    function automatic longint unsigned int_sqrt(input longint unsigned n);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n) b >>= 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic longint lg2_fix(input longint unsigned v);
        int              k;
        longint unsigned y;
        longint          r;
        k = 0;
        while (k < 12 && (v >> (k + 1)) != 0) k++;
        y = v << (30 - k);
        r = longint'(k) << 16;
        for (int b = 15; b >= 0; b--) begin
            y = (y * y) >> 30;
            if (y >= (64'd1 << 31)) begin
                y >>= 1;
                r |= longint'(1) << b;
            end
        end
        return r;
    endfunction

    task automatic build_curves();
        longint unsigned roots [16];
        longint          lx, e, enum_g, eden_g;
        longint unsigned ue, q, f, v, val, gn, gd;
        roots[0] = int_sqrt(64'd2 << 60);
        for (int j = 1; j < 16; j++) roots[j] = int_sqrt(roots[j-1] << 30);
        for (int g = 0; g < 3; g++) begin
            enum_g = (g == 0) ? 2 : (g == 1) ? 3 : 7;
            eden_g = (g == 2) ? 10 : 5;
            gn = (g == 0) ? 4 : (g == 1) ? 6 : 3;
            gd = (g == 2) ? 2 : 5;
            curve[g][0] = '0;
            for (int i = 1; i < DEPTH; i++) begin
                lx = lg2_fix(2 * i) - lg2_fix(DEPTH);
                e  = lx * enum_g / eden_g + (longint'(16) << 16);
                ue = (e < 0) ? 0 : e;
                q  = (ue >> 16) & 31;
                f  = ue & 16'hFFFF;
                v  = 64'd1 << 30;
                for (int j = 0; j < 16; j++)
                    if (f[15-j]) v = (v * roots[j] + (64'd1 << 29)) >> 30;
                val = ((v << q) * gn + (gd << 29)) / (gd << 30);
                curve[g][i] = (val > 65536) ? 17'd65536 : val[16:0];
            end
        end
    endtask

    // ---------------- predictor ----------------
    function automatic int bar_group(input int b);
        return (b < 2) ? 0 : (b < 6) ? 1 : 2;
    endfunction

    function automatic logic [23:0] peak_next(input logic [23:0] pk, input logic [31:0] cur,
                                             input longint unsigned decay);
        longint unsigned p;
        if (cur > pk) begin
            p = (longint'(pk) * 45875 + longint'(cur) * 19661 + 32768) >> 16;
            if (p > 24'hFFFFFF) p = 24'hFFFFFF;
        end else begin
            p = (longint'(pk) * decay + 32768) >> 16;
        end
        if (p < floor_q) p = floor_q;
        return p[23:0];
    endfunction

    task automatic predict_bin(input logic [23:0] mag, input logic [4:0] bin,
                               input logic last);
        longint unsigned term, s, n, idx, lows, mids, highs, lv, t, step, leds;
        logic [31:0]     gmax [3];
        logic [16:0]     tgt  [sble_pkg::BAR_COUNT];
        int              band, g;
        t_bar_item       it;
        band = sble_pkg::BAND_OF_BIN[bin];
        term = (longint'(mag) * sble_pkg::WEIGHT_OF_BIN[bin] + 32768) >> 16;
        s = longint'(band_acc[band]) + term;
        band_acc[band] = (s > 32'hFFFFFFFF) ? 32'hFFFFFFFF : s[31:0];
        if (!last) return;

        gmax = '{default: '0};
        for (int b = 0; b < sble_pkg::BAR_COUNT; b++) begin
            g = bar_group(b);
            if (band_acc[b] > gmax[g]) gmax[g] = band_acc[b];
        end
        grp_peak[0] = peak_next(grp_peak[0], gmax[0], 64881);
        grp_peak[1] = peak_next(grp_peak[1], gmax[1], 65208);
        grp_peak[2] = peak_next(grp_peak[2], gmax[2], 65536);

        for (int b = 0; b < sble_pkg::BAR_COUNT; b++) begin
            g = bar_group(b);
            if (grp_peak[g] == 0) begin
                tgt[b] = '0;
            end else begin
                n = (longint'(band_acc[b]) << 16) / grp_peak[g];
                if (n > 131072) n = 131072;
                idx = (n * DEPTH) >> 17;
                if (idx >= DEPTH) idx = DEPTH - 1;
                tgt[b] = curve[g][idx];
            end
        end
        lows  = tgt[0] + tgt[1];
        mids  = tgt[2] + tgt[3] + tgt[4] + tgt[5];
        highs = tgt[6] + tgt[7];
        if (lows > 52428 && mids <= 19660 && highs <= 13107) begin
            tgt[0] = 17'((longint'(tgt[0]) * 19661 + 32768) >> 16);
            tgt[1] = 17'((longint'(tgt[1]) * 19661 + 32768) >> 16);
        end

        for (int b = 0; b < sble_pkg::BAR_COUNT; b++) begin
            lv = level_q[b];
            t  = tgt[b];
            if (t >= lv) begin
                step = ((t - lv) * rate_q + 128) >> 8;
                lv += step;
            end else begin
                step = ((lv - t) * rate_q + 128) >> 8;
                lv = (step > lv) ? 0 : lv - step;
            end
            if (lv < 66) lv = 0;
            if (lv > 65536) lv = 65536;
            level_q[b] = lv[16:0];
            leds = (lv * LEDS + 32768) >> 16;
            if (leds > LEDS) leds = LEDS;
            it.bar   = 3'(b);
            it.leds  = leds[3:0];
            it.level = lv[16:0];
            it.last  = (b == sble_pkg::BAR_COUNT - 1);
            bars_pending.push_back(it);
            band_acc[b] = '0;
        end
    endtask

    // ---------------- drivers ----------------
    task automatic send_bin(input logic [23:0] mag, input logic [4:0] bin, input logic last);
        int gap;
        gap = tx_idle_en ? $urandom_range(0, 10) : 0;
        if (gap > 0) begin
            i_bin_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_bin_valid <= 1'b1;
        i_magnitude <= mag;
        i_bin_index <= bin;
        i_last_bin  <= last;
        do @(posedge i_clk); while (!o_bin_ready);
        predict_bin(mag, bin, last);
        items_sent++;
    endtask

    task automatic wait_idle();
        i_bin_valid <= 1'b0;
        while (bars_pending.size() != 0) @(posedge i_clk);
        // a trailing bin without last_bin may still be in the adder
        repeat (30) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
        wait_idle();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == sble_pkg::CFG_SMOOTHING_RATE) rate_q = data[7:0];
        else if (idx == sble_pkg::CFG_PEAK_FLOOR) floor_q = data;
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [23:0] rand_mag();
        return 24'($urandom_range(0, 24'hFFFFFF) >> $urandom_range(0, 23));
    endfunction

    task automatic send_frame();
        for (int b = 0; b < sble_pkg::BIN_COUNT; b++)
            send_bin(rand_mag(), b[4:0], b == sble_pkg::BIN_COUNT - 1);
    endtask

    // ---------------- receiver and checker ----------------
    always @(posedge i_clk) begin
        int  cnt;
        logic nxt;
        if (!i_rst_n) begin
            i_bar_ready <= 1'b0;
            rx_wait = 0;
            hold_ack = hold_req;
        end else begin
            cnt = rx_wait;
            if (o_bar_valid && i_bar_ready)
                cnt = rx_idle_en ? $urandom_range(0, 10) : 0;
            if (hold_req != hold_ack) begin
                cnt = HOLD_LEN;
                hold_ack = hold_req;
            end
            if (cnt > 0) begin
                cnt--;
                nxt = 1'b0;
            end else begin
                nxt = 1'b1;
            end
            rx_wait = cnt;
            i_bar_ready <= nxt;
        end
    end

    always @(posedge i_clk) begin
        t_bar_item want;
        if (i_rst_n && o_bar_valid && i_bar_ready) begin
            if (bars_pending.size() == 0) begin
                report("unexpected bar", o_bar_index, -1);
            end else begin
                want = bars_pending.pop_front();
                if (o_bar_index != want.bar)   report("bar_index", o_bar_index, want.bar);
                if (o_led_count != want.leds)  report("led_count", o_led_count, want.leds);
                if (o_bar_level != want.level) report("bar_level", o_bar_level, want.level);
                if (o_last_bar != want.last)   report("last_bar", o_last_bar, want.last);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_bin_valid && o_bin_ready) || (o_bar_valid && i_bar_ready)
                || (i_cfg_valid && o_cfg_ready) || !i_rst_n) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_MAX) begin
            $display("status: fail");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // ---------------- tests ----------------
    task automatic test_directed();
        // extremes, dead bins, repeated and missing bins
        send_bin(24'hFFFFFF, 5'd0, 1'b0);
        send_bin(24'hFFFFFF, 5'd31, 1'b0);
        send_bin(24'h000000, 5'd1, 1'b0);
        send_bin(24'hFFFFFF, 5'd22, 1'b0);
        send_bin(24'hFFFFFF, 5'd22, 1'b0);
        send_bin(24'h800000, 5'd16, 1'b0);
        send_bin(24'h7FFFFF, 5'd29, 1'b1);
        // frame made of the last-bin item only
        send_bin(24'h000000, 5'd31, 1'b1);
        // only the low group loud: bars 0 and 1 damped
        for (int i = 0; i < 3; i++) begin
            send_bin(24'h0F0000, 5'd1, 1'b0);
            send_bin(24'h0F0000, 5'd2, 1'b0);
            send_bin(24'h0F0000, 5'd5, 1'b1);
        end
        send_bin(24'h555555, 5'd10, 1'b0);
        send_bin(24'hAAAAAA, 5'd21, 1'b1);
    endtask

    task automatic test_peak_saturation();
        // a large high band saturates the high peak and the normalized value
        for (int i = 0; i < 20; i++)
            send_bin(24'hFFFFFF, 5'd24, i == 19);
        send_bin(24'h000001, 5'd24, 1'b1);
    endtask

    task automatic test_config_extremes();
        write_reg(sble_pkg::CFG_SMOOTHING_RATE, 16'd255);
        write_reg(sble_pkg::CFG_PEAK_FLOOR, 16'd0);
        send_frame();
        send_frame();
        write_reg(sble_pkg::CFG_SMOOTHING_RATE, 16'hFF00);
        send_frame();
        write_reg(sble_pkg::CFG_PEAK_FLOOR, 16'hFFFF);
        write_reg(sble_pkg::CFG_SMOOTHING_RATE, 16'd1);
        send_frame();
        // unused register indexes are ignored
        write_reg(2'd2, 16'hA5A5);
        write_reg(2'd3, 16'h5A5A);
        send_frame();
        write_reg(sble_pkg::CFG_SMOOTHING_RATE, 16'd77);
        write_reg(sble_pkg::CFG_PEAK_FLOOR, 16'd655);
    endtask

    task automatic test_output_backpressure();
        tx_idle_en = 1'b0;
        hold_req = ~hold_req;
        send_frame();
        send_frame();
        tx_idle_en = 1'b1;
    endtask

    task automatic test_random_frames();
        int kind, n, start;
        start = items_sent;
        while (items_sent - start < 90) begin
            kind = $urandom_range(0, 9);
            if (kind < 7) begin
                send_frame();
            end else if (kind < 9) begin
                n = $urandom_range(1, 12);
                for (int i = 0; i < n; i++)
                    send_bin(rand_mag(), 5'($urandom_range(0, 31)), i == n - 1);
            end else begin
                send_bin(rand_mag(), 5'($urandom_range(0, 31)), 1'b0);
            end
            if ($urandom_range(0, 7) == 0)
                write_reg(2'($urandom_range(0, 3)), 16'($urandom_range(0, 65535)));
            tx_idle_en = ($urandom_range(0, 3) != 0);
            rx_idle_en = ($urandom_range(0, 3) != 0);
        end
    endtask

    initial begin
        i_rst_n     <= 1'b0;
        i_bin_valid <= 1'b0;
        i_magnitude <= '0;
        i_bin_index <= '0;
        i_last_bin  <= 1'b0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data  <= '0;
        items_sent = 0;
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
        rate_q  = sble_pkg::SMOOTH_RESET;
        floor_q = sble_pkg::FLOOR_RESET;
        band_acc = '{default: '0};
        level_q  = '{default: '0};
        grp_peak[0] = sble_pkg::PEAK_LOW_RESET;
        grp_peak[1] = sble_pkg::PEAK_MID_RESET;
        grp_peak[2] = sble_pkg::PEAK_HIGH_RESET;
        build_curves();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_peak_saturation();
        test_config_extremes();
        test_output_backpressure();
        test_random_frames();

        i_bin_valid <= 1'b0;
        while (bars_pending.size() != 0) @(posedge i_clk);
        repeat (250) @(posedge i_clk);
        if (err_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
